/* src/mkps_pkg.sv */
// Shared types and constants for the 4x4 keypad matrix scanner.
// No dependencies; used by mkps_scan_fsm and matrix_keypad_scanner_unit.
`default_nettype none

package mkps_pkg;

   // Scan sequencer phases
   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_SCAN     = 2'd2,
      PH_RELEASE  = 2'd3
   } phase_type;

   // Row order is row 4 first, then rows 1..3
   localparam logic [1:0] FIRST_ROW = 2'd3;
   localparam logic [1:0] LAST_ROW  = 2'd2;

   localparam int          DEBOUNCE_BITS  = 16;
   localparam logic [15:0] DEBOUNCE_RESET = 16'd5;

   localparam logic [3:0] ALL_ROWS = 4'hF;

   // One result item
   typedef struct packed {
      logic [3:0] row_drive;
      logic       key_ready;
      logic [4:0] key_code;
      logic       no_press;
   } rsp_type;

endpackage

`default_nettype wire

/* src/mkps_scan_fsm.sv */
// Scan sequencer: phase, row, debounce counter and stored key code.
// Depends on mkps_pkg. Updates state on each fired item and gives its result.
`default_nettype none

module mkps_scan_fsm #(
   parameter int COUNT_BITS = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   fire,
   input  wire [3:0]             column_lines,
   input  wire [15:0]            debounce_ticks,
   output mkps_pkg::rsp_type     result
);

   localparam int LIM_W = ((COUNT_BITS > mkps_pkg::DEBOUNCE_BITS) ?
                           COUNT_BITS : mkps_pkg::DEBOUNCE_BITS) + 1;

   mkps_pkg::phase_type   phase_ff, phase_in;
   logic [1:0]            row_ff, row_in;
   logic [COUNT_BITS-1:0] wait_ff, wait_in;
   logic [4:0]            key_ff, key_in;

   logic [LIM_W-1:0]      deb_ext;
   logic [LIM_W-1:0]      cnt_max;
   logic [COUNT_BITS-1:0] limit;
   logic                  hot_ok;
   logic [1:0]            hot_col;

   // Debounce limit saturated to the counter range
   always_comb begin
      deb_ext = {{(LIM_W-mkps_pkg::DEBOUNCE_BITS){1'b0}}, debounce_ticks};
      cnt_max = {{(LIM_W-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};
      if (deb_ext > cnt_max) begin
         limit = {COUNT_BITS{1'b1}};
      end else begin
         limit = deb_ext[COUNT_BITS-1:0];
      end
   end

   // One-hot column decode
   always_comb begin
      hot_ok  = 1'b1;
      hot_col = 2'd0;
      case (column_lines)
         4'b0001: hot_col = 2'd0;
         4'b0010: hot_col = 2'd1;
         4'b0100: hot_col = 2'd2;
         4'b1000: hot_col = 2'd3;
         default: hot_ok  = 1'b0;
      endcase
   end

   // Next state and result
   always_comb begin
      phase_in         = phase_ff;
      row_in           = row_ff;
      wait_in          = wait_ff;
      key_in           = key_ff;
      result.key_ready = 1'b0;
      result.no_press  = 1'b0;
      case (phase_ff)
         mkps_pkg::PH_IDLE: begin
            if (column_lines != 4'd0) begin
               phase_in = mkps_pkg::PH_DEBOUNCE;
               wait_in  = '0;
            end
         end
         mkps_pkg::PH_DEBOUNCE: begin
            if (wait_ff < limit) begin
               wait_in = wait_ff + COUNT_BITS'(1);
            end else if (column_lines == 4'd0) begin
               result.no_press = 1'b1;
               phase_in        = mkps_pkg::PH_IDLE;
            end else begin
               row_in   = mkps_pkg::FIRST_ROW;
               phase_in = mkps_pkg::PH_SCAN;
            end
         end
         mkps_pkg::PH_SCAN: begin
            if (hot_ok) begin
               key_in = {1'b0, hot_col, row_ff} + 5'd1;
            end
            phase_in = mkps_pkg::PH_RELEASE;
         end
         default: begin
            if (column_lines == 4'd0) begin
               if (row_ff == mkps_pkg::LAST_ROW) begin
                  result.key_ready = 1'b1;
                  phase_in         = mkps_pkg::PH_IDLE;
               end else begin
                  row_in   = row_ff + 2'd1;
                  phase_in = mkps_pkg::PH_SCAN;
               end
            end
         end
      endcase
      if (phase_in == mkps_pkg::PH_SCAN || phase_in == mkps_pkg::PH_RELEASE) begin
         result.row_drive = 4'd1 << row_in;
      end else begin
         result.row_drive = mkps_pkg::ALL_ROWS;
      end
      result.key_code = key_in;
   end

   // State registers advance only on a fired item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mkps_pkg::PH_IDLE;
         row_ff   <= 2'd0;
         wait_ff  <= '0;
         key_ff   <= 5'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         row_ff   <= row_in;
         wait_ff  <= wait_in;
         key_ff   <= key_in;
      end
   end

endmodule

`default_nettype wire

/* src/matrix_keypad_scanner_unit.sv */
// Top level of the 4x4 keypad matrix scanner: input register, sequencer,
// result register and debounce register. Depends on mkps_pkg, mkps_scan_fsm.
//
//   channel  dir  ports                                        handshake
//   req      in   req_column_lines                             req_valid / req_stall
//   rsp      out  rsp_row_drive rsp_key_ready rsp_key_code     rsp_valid / rsp_stall
//                 rsp_no_press
//   csr      in   csr_wr_data (debounce_ticks)                 csr_wr_en
//
// One item per cycle sustained while rsp is not stalled; each item passes the input
// register, then the sequencer update into the result register.
// The result register moves when it is empty or its item is taken; a stall on
// rsp holds both registers and raises req_stall only while the input register
// is full. Synchronous reset empties both registers, idles the sequencer and
// sets debounce_ticks to 5.
`default_nettype none

module matrix_keypad_scanner_unit #(
   parameter int COUNT_BITS = 16
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [3:0]  req_column_lines,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [3:0] rsp_row_drive,
   output logic       rsp_key_ready,
   output logic [4:0] rsp_key_code,
   output logic       rsp_no_press,
   input  wire        csr_wr_en,
   input  wire [15:0] csr_wr_data
);

   logic              in_valid_ff;
   logic [3:0]        in_cols_ff;
   logic              out_valid_ff;
   mkps_pkg::rsp_type out_ff;
   mkps_pkg::rsp_type result;
   logic [15:0]       debounce_ff;
   logic              out_free;
   logic              fire;

   // Pipeline flow
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Debounce register
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= mkps_pkg::DEBOUNCE_RESET;
      end else if (csr_wr_en) begin
         debounce_ff <= csr_wr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_cols_ff <= req_column_lines;
      end
   end

   mkps_scan_fsm #(
      .COUNT_BITS (COUNT_BITS)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .column_lines   (in_cols_ff),
      .debounce_ticks (debounce_ff),
      .result         (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_row_drive = out_ff.row_drive;
   assign rsp_key_ready = out_ff.key_ready;
   assign rsp_key_code  = out_ff.key_code;
   assign rsp_no_press  = out_ff.no_press;

   // Checks
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.key_ready && out_ff.no_press))
      else $error("key_ready and no_press together");

   a_row_drive_shape: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.row_drive == mkps_pkg::ALL_ROWS ||
                        $onehot(out_ff.row_drive)))
      else $error("row drive neither all rows nor one row");

   a_key_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.key_code <= 5'd16))
      else $error("key code out of range");

   a_ready_all_rows: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.key_ready || out_ff.no_press)) |->
         (out_ff.row_drive == mkps_pkg::ALL_ROWS))
      else $error("scan end without all rows driven");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_ff)))
      else $error("stalled result changed");

endmodule

`default_nettype wire

/* tb/keypad_scan_checker.sv */
// Result checker for the keypad scanner: watches the req, rsp and csr ports,
// predicts each result item and compares it. Depends on mkps_pkg.
`timescale 1ns / 100ps

module keypad_scan_checker #(
   parameter int COUNT_BITS = 16
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   input  wire        req_stall,
   input  wire [3:0]  req_column_lines,
   input  wire        rsp_valid,
   input  wire        rsp_stall,
   input  wire [3:0]  rsp_row_drive,
   input  wire        rsp_key_ready,
   input  wire [4:0]  rsp_key_code,
   input  wire        rsp_no_press,
   input  wire        csr_wr_en,
   input  wire [15:0] csr_wr_data,
   output int         fail_total,
   output int         outstanding,
   output int         key_reports,
   output int         none_reports
);

   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
   localparam int PRINT_LIMIT = 25;

   // Scanner state as predicted
   mkps_pkg::phase_type   phase_q;
   logic [1:0]            row_sel;
   logic [COUNT_BITS-1:0] settle_cnt;
   logic [4:0]            last_key;
   logic [15:0]           debounce_cfg;

   mkps_pkg::rsp_type awaited_results[$];
   int      mismatches;
   int      results_seen;
   int      scans_done;
   int      empty_checks;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("[%0t] result %0d: %s", $time, results_seen, msg);
   endtask

   // One tick of the scan sequencer
   task automatic advance_scanner(input logic [3:0] cols, output mkps_pkg::rsp_type res);
      longint unsigned limit;
      logic [1:0]      col_pos;
      bit              single;
      res.key_ready = 1'b0;
      res.no_press  = 1'b0;
      case (phase_q)
         mkps_pkg::PH_IDLE: begin
            if (cols != 4'h0) begin
               phase_q    = mkps_pkg::PH_DEBOUNCE;
               settle_cnt = '0;
            end
         end
         mkps_pkg::PH_DEBOUNCE: begin
            // register value saturates at the counter range
            limit = longint'(debounce_cfg);
            if (limit > COUNT_MAX) limit = COUNT_MAX;
            if (longint'(settle_cnt) < limit) begin
               settle_cnt = settle_cnt + COUNT_BITS'(1);
            end else if (cols == 4'h0) begin
               res.no_press = 1'b1;
               phase_q      = mkps_pkg::PH_IDLE;
            end else begin
               row_sel = mkps_pkg::FIRST_ROW;
               phase_q = mkps_pkg::PH_SCAN;
            end
         end
         mkps_pkg::PH_SCAN: begin
            single = 1'b1;
            col_pos = 2'd0;
            case (cols)
               4'h1: col_pos = 2'd0;
               4'h2: col_pos = 2'd1;
               4'h4: col_pos = 2'd2;
               4'h8: col_pos = 2'd3;
               default: single = 1'b0;
            endcase
            // several columns at once leave the stored code alone
            if (single) last_key = 5'(int'(col_pos) * 4 + int'(row_sel) + 1);
            phase_q = mkps_pkg::PH_RELEASE;
         end
         default: begin
            if (cols == 4'h0) begin
               if (row_sel == mkps_pkg::LAST_ROW) begin
                  res.key_ready = 1'b1;
                  phase_q       = mkps_pkg::PH_IDLE;
               end else begin
                  row_sel = row_sel + 2'd1;
                  phase_q = mkps_pkg::PH_SCAN;
               end
            end
         end
      endcase
      if (phase_q == mkps_pkg::PH_SCAN || phase_q == mkps_pkg::PH_RELEASE)
         res.row_drive = 4'b0001 << row_sel;
      else
         res.row_drive = mkps_pkg::ALL_ROWS;
      res.key_code = last_key;
   endtask

   task automatic check_result();
      mkps_pkg::rsp_type want;
      results_seen++;
      if (awaited_results.size() == 0) begin
         report_mismatch($sformatf(
            "item with none outstanding: rows %h ready %b code %0d none %b",
            rsp_row_drive, rsp_key_ready, rsp_key_code, rsp_no_press));
         return;
      end
      want = awaited_results.pop_front();
      if (rsp_row_drive !== want.row_drive)
         report_mismatch($sformatf("row_drive %h, predicted %h", rsp_row_drive, want.row_drive));
      if (rsp_key_ready !== want.key_ready)
         report_mismatch($sformatf("key_ready %b, predicted %b", rsp_key_ready, want.key_ready));
      if (rsp_key_code !== want.key_code)
         report_mismatch($sformatf("key_code %0d, predicted %0d", rsp_key_code, want.key_code));
      if (rsp_no_press !== want.no_press)
         report_mismatch($sformatf("no_press %b, predicted %b", rsp_no_press, want.no_press));
   endtask

   always @(posedge clock) begin
      mkps_pkg::rsp_type next_res;
      if (reset) begin
         phase_q      = mkps_pkg::PH_IDLE;
         row_sel      = 2'd0;
         settle_cnt   = '0;
         last_key     = 5'd0;
         debounce_cfg = mkps_pkg::DEBOUNCE_RESET;
         awaited_results.delete();
      end else begin
         if (csr_wr_en) debounce_cfg = csr_wr_data;
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) begin
            advance_scanner(req_column_lines, next_res);
            awaited_results.push_back(next_res);
            if (next_res.key_ready) scans_done++;
            if (next_res.no_press) empty_checks++;
         end
      end
      fail_total   <= mismatches;
      outstanding  <= awaited_results.size();
      key_reports  <= scans_done;
      none_reports <= empty_checks;
   end

endmodule

/* tb/tb_top.sv */
// Testbench top for matrix_keypad_scanner_unit: clock, reset, column stimulus,
// receiver stalls and verdict. Depends on the scanner RTL and keypad_scan_checker.
`timescale 1ns / 100ps

module tb_top;

   localparam int RESET_CYCLES = 12;
   localparam int ITEM_GOAL    = 1550;
   localparam int PHASE_ITEMS  = 150;
   localparam int HOLD_CYCLES  = 120;
   localparam int QUIET_LIMIT  = 3000;

   // Opening sequence at zero debounce: row 4 / column 4 press, a bounce,
   // then several columns on row 4 followed by a real press on row 1
   localparam logic [3:0] OPENING [24] = '{
      4'h8, 4'h8, 4'h8, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
      4'h1, 4'h0,
      4'hF, 4'hF, 4'hF, 4'h0, 4'h1, 4'h1, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_column_lines = 4'h0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_row_drive;
   logic        rsp_key_ready;
   logic [4:0]  rsp_key_code;
   logic        rsp_no_press;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;

   int fail_total;
   int outstanding;
   int key_reports;
   int none_reports;
   int items_sent;
   int debounce_now = 5;
   int quiet_cycles;
   bit calm;
   bit hold_off_req;
   bit hold_active;

   always #6 clock = ~clock;

   matrix_keypad_scanner_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_column_lines (req_column_lines),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_drive    (rsp_row_drive),
      .rsp_key_ready    (rsp_key_ready),
      .rsp_key_code     (rsp_key_code),
      .rsp_no_press     (rsp_no_press),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   keypad_scan_checker scan_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_column_lines (req_column_lines),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_drive    (rsp_row_drive),
      .rsp_key_ready    (rsp_key_ready),
      .rsp_key_code     (rsp_key_code),
      .rsp_no_press     (rsp_no_press),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .fail_total       (fail_total),
      .outstanding      (outstanding),
      .key_reports      (key_reports),
      .none_reports     (none_reports)
   );

   // Mostly no gap, some short ones, a few long; none in calm stretches
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (calm) return 0;
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic send_cols(input logic [3:0] cols);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_column_lines <= cols;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Drain the pipeline so the register can be written safely
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_debounce(input logic [15:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      debounce_now = value;
   endtask

   // Zeros long enough to bring the sequencer back to idle from any phase
   task automatic resync();
      repeat (debounce_now + 10) send_cols(4'h0);
   endtask

   // Full press from idle; hit_col 4 = no row matches, 5 = several columns
   task automatic scan_key(input int hit_row, input int hit_col);
      logic [3:0] cols;
      int row;
      int held;
      send_cols(4'($urandom_range(1, 15)));
      repeat (debounce_now) send_cols(4'($urandom_range(0, 15)));
      send_cols(4'($urandom_range(1, 15)));
      for (int step = 0; step < 4; step++) begin
         row = (step + 3) % 4;
         if (row != hit_row) begin
            cols = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'h0;
         end else if (hit_col < 4) begin
            cols = 4'(1 << hit_col);
         end else if (hit_col == 4) begin
            cols = 4'h0;
         end else begin
            do cols = 4'($urandom_range(3, 15)); while (cols == 4'h4 || cols == 4'h8);
         end
         send_cols(cols);
         held = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         repeat (held) send_cols(4'($urandom_range(1, 15)));
         send_cols(4'h0);
      end
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int run;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_active = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
            hold_active  = 1'b0;
         end
         rsp_stall <= 1'b0;
         run = $urandom_range(1, 24);
         repeat (run) @(posedge clock);
         run = idle_gap();
         if (run > 0) begin
            rsp_stall <= 1'b1;
            repeat (run) @(posedge clock);
         end
      end
   end

   // Watchdog on cycles where no item moves on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: %0d cycles without an item moving", quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int pick;
      int phase_end;
      int hit_col;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // idle with nothing pressed, at the reset debounce
      send_cols(4'h0);
      settle();
      write_debounce(16'h0000);
      foreach (OPENING[i]) send_cols(OPENING[i]);

      // largest debounce: start a wait, then cut it short with a small setting
      settle();
      write_debounce(16'hFFFF);
      send_cols(4'h4);
      repeat (20) send_cols(4'($urandom_range(0, 15)));
      settle();
      write_debounce(16'd3);
      send_cols(4'h0);

      // receiver holds off while presses keep coming in back to back
      settle();
      write_debounce(16'd2);
      calm = 1'b1;
      hold_off_req = 1'b1;
      wait (hold_active);
      repeat (4) scan_key($urandom_range(0, 3), $urandom_range(0, 3));
      calm = 1'b0;

      // random phases, each with its own debounce setting
      while (items_sent < ITEM_GOAL) begin
         settle();
         pick = $urandom_range(0, 9);
         if (pick < 3) write_debounce(16'($urandom_range(0, 2)));
         else if (pick < 8) write_debounce(16'($urandom_range(3, 8)));
         else write_debounce(16'($urandom_range(9, 20)));
         calm = ($urandom_range(0, 3) == 0);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               hit_col = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 5)
                                                     : $urandom_range(0, 3);
               scan_key($urandom_range(0, 3), hit_col);
            end else if (pick < 80) begin
               // bounce: gone by the confirming check
               send_cols(4'($urandom_range(1, 15)));
               repeat (debounce_now) send_cols(4'($urandom_range(0, 15)));
               send_cols(4'h0);
            end else if (pick < 88) begin
               // key held through release for a long while
               send_cols(4'($urandom_range(1, 15)));
               repeat (debounce_now) send_cols(4'($urandom_range(0, 15)));
               send_cols(4'($urandom_range(1, 15)));
               send_cols(4'($urandom_range(1, 15)));
               repeat ($urandom_range(15, 40)) send_cols(4'($urandom_range(1, 15)));
               resync();
            end else begin
               repeat ($urandom_range(1, 10)) send_cols(4'($urandom_range(0, 15)));
               resync();
            end
         end
      end
      calm = 1'b0;

      settle();
      $display("Sent %0d column samples over debounce settings from 0 to 65535,", items_sent);
      $display("with %0d finished scans and %0d empty debounce checks predicted.",
               key_reports, none_reports);
      if (fail_total == 0 && outstanding == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

/* sim.f */
src/mkps_pkg.sv
src/mkps_scan_fsm.sv
src/matrix_keypad_scanner_unit.sv
tb/keypad_scan_checker.sv
tb/tb_top.sv
